// ===== hdl/chip8_pkg.sv =====
`default_nettype none
package chip8_pkg;

  localparam int RAM_BYTES     = 4096;
  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_PIXELS = 2048;
  localparam int STACK_DEPTH   = 16;
  localparam int PROGRAM_START = 512;

  localparam int RAM_AW = $clog2(RAM_BYTES);
  localparam int SCR_AW = $clog2(SCREEN_PIXELS);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = SCR_AW - COL_W;
  localparam int SP_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int FONT_BYTES = 80;

  // request kinds
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_EXEC  = 2'd1;
  localparam logic [1:0] REQ_PIXEL = 2'd2;

  // opcode groups (top nibble)
  localparam logic [3:0] GRP_SYS   = 4'h0;
  localparam logic [3:0] GRP_JP    = 4'h1;
  localparam logic [3:0] GRP_CALL  = 4'h2;
  localparam logic [3:0] GRP_SE    = 4'h3;
  localparam logic [3:0] GRP_SNE   = 4'h4;
  localparam logic [3:0] GRP_SEXY  = 4'h5;
  localparam logic [3:0] GRP_LD    = 4'h6;
  localparam logic [3:0] GRP_ADD   = 4'h7;
  localparam logic [3:0] GRP_ALU   = 4'h8;
  localparam logic [3:0] GRP_SNEXY = 4'h9;
  localparam logic [3:0] GRP_LDI   = 4'hA;
  localparam logic [3:0] GRP_JPV0  = 4'hB;
  localparam logic [3:0] GRP_RND   = 4'hC;
  localparam logic [3:0] GRP_DRW   = 4'hD;
  localparam logic [3:0] GRP_SKP   = 4'hE;
  localparam logic [3:0] GRP_MISC  = 4'hF;

  localparam logic [7:0] SYS_CLS = 8'hE0;
  localparam logic [7:0] SYS_RET = 8'hEE;

  localparam logic [3:0] ALU_MOV  = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  localparam logic [7:0] SKP_DOWN = 8'h9E;
  localparam logic [7:0] SKP_UP   = 8'hA1;

  localparam logic [7:0] F_GET_DT   = 8'h07;
  localparam logic [7:0] F_WAIT_KEY = 8'h0A;
  localparam logic [7:0] F_SET_DT   = 8'h15;
  localparam logic [7:0] F_SET_ST   = 8'h18;
  localparam logic [7:0] F_ADD_I    = 8'h1E;
  localparam logic [7:0] F_FONT     = 8'h29;
  localparam logic [7:0] F_BCD      = 8'h33;
  localparam logic [7:0] F_STORE    = 8'h55;
  localparam logic [7:0] F_LOAD     = 8'h65;

  localparam logic [3:0] REG_FLAG = 4'hF;

  localparam logic [7:0] FONT [FONT_BYTES] = '{
    8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
    8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
    8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
    8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
    8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
    8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
    8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
    8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80
  };

  typedef struct packed {
    logic [7:0] val;
    logic       wr;
    logic       flag;
    logic       flag_wr;
    logic       bad;
  } alu_res_t;

  typedef struct packed {
    logic [7:0] hundreds;
    logic [7:0] tens;
    logic [7:0] ones;
  } bcd_t;

endpackage
`default_nettype wire

// ===== hdl/chip8_instruction_core.sv =====
`default_nettype none
// A RAM load writes one byte, a pixel read reads the screen RAM, and an instruction
// fetches, reads operands and executes; flag-setting ALU ops, FX1E and DXYN then write VF.
// DXYN updates lit pixels row by row; 00E0 clears one pixel per cycle; FX33/FX55/FX65 loop.
// Throughput: one request at a time; the next is taken once the result is registered (not stalled).
// Reset: synchronous; a clearing pass then writes font/zero to RAM and clears the
// screen, V registers and call stack; no request is accepted until it ends.
module chip8_instruction_core import chip8_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [11:0] address, [19:12] data, [35:20] key_mask, [43:36] random_byte
  input  wire logic [47:0] s_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] pixel, [1] drew, [2] sound_on, [14:3] program_counter, [15] bad_opcode
  output logic      [15:0] m_tdata
);
  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_LOAD    = 5'd2;
  localparam logic [4:0] S_PIXRD   = 5'd3;
  localparam logic [4:0] S_PIXLAT  = 5'd4;
  localparam logic [4:0] S_FETCHHI = 5'd5;
  localparam logic [4:0] S_FETCHLO = 5'd6;
  localparam logic [4:0] S_OPLO    = 5'd7;
  localparam logic [4:0] S_RDX     = 5'd8;
  localparam logic [4:0] S_RDY     = 5'd9;
  localparam logic [4:0] S_RD0     = 5'd10;
  localparam logic [4:0] S_EXEC    = 5'd11;
  localparam logic [4:0] S_CLS     = 5'd12;
  localparam logic [4:0] S_WRF     = 5'd13;
  localparam logic [4:0] S_DROW    = 5'd14;
  localparam logic [4:0] S_DBYTE   = 5'd15;
  localparam logic [4:0] S_DPIX    = 5'd16;
  localparam logic [4:0] S_DRMW    = 5'd17;
  localparam logic [4:0] S_BCD     = 5'd18;
  localparam logic [4:0] S_STRD    = 5'd19;
  localparam logic [4:0] S_STWR    = 5'd20;
  localparam logic [4:0] S_LDRD    = 5'd21;
  localparam logic [4:0] S_LDWR    = 5'd22;
  localparam logic [4:0] S_TIMER   = 5'd23;
  localparam logic [4:0] S_DONE    = 5'd24;

  logic [4:0]  state;
  logic [11:0] cnt;      // sweep / row / register loop counter
  logic [2:0]  bitpos;   // sprite column
  // latched request
  logic [1:0]  req_op;
  logic [11:0] req_addr;
  logic [7:0]  req_data;
  logic [15:0] keys;
  logic [7:0]  rnd;
  // architectural state held in flops
  logic [11:0] pc;
  logic [15:0] index;
  logic [SP_W-1:0] sp;
  logic [7:0]  delay, sound;
  // instruction working registers
  logic [15:0] opc;
  logic [7:0]  vx, vy, v0, row_byte;
  logic        coll, flag;
  logic        drew, bad, snd, pix;

  // memory ports
  logic              ram_we, scr_we, reg_we, stk_we;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic [SCR_AW-1:0] scr_waddr, scr_raddr;
  logic              scr_wdata, scr_rdata;
  logic [3:0]        reg_waddr, reg_raddr;
  logic [7:0]        reg_wdata, reg_rdata;
  logic [SP_W-1:0]   stk_waddr, sp_inc, sp_dec;
  logic [11:0]       stk_wdata, stk_rdata;

  alu_res_t alu;
  bcd_t     bcd;

  // decode fields
  logic [3:0]  grp, rx, nlo;
  logic [7:0]  nn;
  logic [11:0] nnn, pc2, pc4, iptr;
  logic [16:0] isum;
  logic [SCR_AW-1:0] pix_addr;
  logic [ROW_W-1:0]  prow;
  logic        key_hit, out_load, row_last;

  assign grp = opc[15:12];
  assign rx  = opc[11:8];
  assign nlo = opc[3:0];
  assign nn  = opc[7:0];
  assign nnn = opc[11:0];
  assign pc2 = pc + 12'd2;
  assign pc4 = pc + 12'd4;
  assign iptr = index[11:0] + {8'd0, cnt[3:0]};
  assign isum = {1'b0, index} + {9'd0, vx};
  assign key_hit = keys[vx[3:0]];
  assign row_last = ({8'd0, cnt[3:0]} + 12'd1 == {8'd0, nlo});

  // wrapped linear pixel: vx + j + (vy + i) * width, modulo pixel count
  assign prow = ROW_W'(vy) + ROW_W'(cnt[3:0]);
  assign pix_addr = SCR_AW'({3'd0, vx} + {8'd0, bitpos}) + {prow, {COL_W{1'b0}}};

  assign sp_inc = (sp == SP_W'(STACK_DEPTH - 1)) ? '0 : sp + 1'b1;
  assign sp_dec = (sp == '0) ? SP_W'(STACK_DEPTH - 1) : sp - 1'b1;

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  chip8_alu u_alu (
    .opc(opc), .vx(vx), .vy(vy), .delay(delay), .keys(keys), .rnd(rnd),
    .res(alu), .bcd(bcd)
  );

  chip8_ram #(.DEPTH(RAM_BYTES), .WIDTH(8)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  chip8_ram #(.DEPTH(SCREEN_PIXELS), .WIDTH(1)) u_screen (
    .clk(clk), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
    .raddr(scr_raddr), .rdata(scr_rdata)
  );

  chip8_ram #(.DEPTH(16), .WIDTH(8)) u_regs (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .rdata(reg_rdata)
  );

  // return stack is read at sp-1 all the time; valid in the cycle after sp settles
  chip8_ram #(.DEPTH(STACK_DEPTH), .WIDTH(12)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(sp_dec), .rdata(stk_rdata)
  );

  // memory port steering, by state
  always_comb begin
    ram_we = 1'b0; ram_waddr = '0; ram_wdata = '0; ram_raddr = '0;
    scr_we = 1'b0; scr_waddr = '0; scr_wdata = 1'b0; scr_raddr = '0;
    reg_we = 1'b0; reg_waddr = '0; reg_wdata = '0; reg_raddr = '0;
    stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = (cnt < 12'(FONT_BYTES)) ? FONT[cnt[6:0]] : 8'd0;
        scr_we    = 1'b1;
        scr_waddr = cnt[SCR_AW-1:0];
        reg_we    = (cnt[11:4] == 8'd0);
        reg_waddr = cnt[3:0];
        stk_we    = (cnt < 12'(STACK_DEPTH));
        stk_waddr = cnt[SP_W-1:0];
      end
      S_LOAD: begin
        ram_we = 1'b1; ram_waddr = req_addr; ram_wdata = req_data;
      end
      S_PIXRD:   scr_raddr = req_addr[SCR_AW-1:0];
      S_FETCHHI: ram_raddr = pc;
      S_FETCHLO: ram_raddr = pc + 12'd1;
      S_OPLO:    reg_raddr = opc[11:8];
      S_RDX:     reg_raddr = opc[7:4];
      S_RDY:     reg_raddr = 4'd0;
      S_EXEC: begin
        reg_we = alu.wr; reg_waddr = rx; reg_wdata = alu.val;
        stk_we = (grp == GRP_CALL); stk_waddr = sp; stk_wdata = pc2;
      end
      S_WRF: begin
        reg_we = 1'b1; reg_waddr = REG_FLAG; reg_wdata = {7'd0, flag};
      end
      S_CLS: begin
        scr_we = 1'b1; scr_waddr = cnt[SCR_AW-1:0];
      end
      S_DROW: ram_raddr = iptr;
      S_DPIX: scr_raddr = pix_addr;
      S_DRMW: begin
        scr_we = 1'b1; scr_waddr = pix_addr; scr_wdata = ~scr_rdata;
      end
      S_BCD: begin
        ram_we = 1'b1; ram_waddr = iptr;
        if (cnt[1:0] == 2'd0)      ram_wdata = bcd.hundreds;
        else if (cnt[1:0] == 2'd1) ram_wdata = bcd.tens;
        else                       ram_wdata = bcd.ones;
      end
      S_STRD: reg_raddr = cnt[3:0];
      S_STWR: begin
        ram_we = 1'b1; ram_waddr = iptr; ram_wdata = reg_rdata;
      end
      S_LDRD: ram_raddr = iptr;
      S_LDWR: begin
        reg_we = 1'b1; reg_waddr = cnt[3:0]; reg_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      pc    <= 12'(PROGRAM_START);
      index <= '0;
      sp    <= '0;
      delay <= '0;
      sound <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 12'd1;
          if (cnt == 12'(RAM_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_tvalid) begin
          req_op   <= s_tuser;
          req_addr <= s_tdata[11:0];
          req_data <= s_tdata[19:12];
          keys     <= s_tdata[35:20];
          rnd      <= s_tdata[43:36];
          drew <= 1'b0; bad <= 1'b0; pix <= 1'b0;
          if (s_tuser == REQ_LOAD)       state <= S_LOAD;
          else if (s_tuser == REQ_EXEC)  state <= S_FETCHHI;
          else if (s_tuser == REQ_PIXEL) state <= S_PIXRD;
          else                           state <= S_DONE;
        end
        S_LOAD:    state <= S_DONE;
        S_PIXRD:   state <= S_PIXLAT;
        S_PIXLAT:  begin pix <= scr_rdata; state <= S_DONE; end
        S_FETCHHI: state <= S_FETCHLO;
        S_FETCHLO: begin opc[15:8] <= ram_rdata; state <= S_OPLO; end
        S_OPLO:    begin opc[7:0] <= ram_rdata; state <= S_RDX; end
        S_RDX:     begin vx <= reg_rdata; state <= S_RDY; end
        S_RDY:     begin vy <= reg_rdata; state <= S_RD0; end
        S_RD0:     begin v0 <= reg_rdata; state <= S_EXEC; end
        S_EXEC: begin
          pc    <= pc2;
          cnt   <= '0;
          bad   <= alu.bad;
          flag  <= alu.flag;
          state <= alu.flag_wr ? S_WRF : S_TIMER;
          unique case (grp)
            GRP_SYS: begin
              if (nn == SYS_CLS) begin
                drew <= 1'b1; state <= S_CLS;
              end else if (nn == SYS_RET) begin
                sp <= sp_dec; pc <= stk_rdata;
              end else bad <= 1'b1;
            end
            GRP_JP:    pc <= nnn;
            GRP_CALL:  begin sp <= sp_inc; pc <= nnn; end
            GRP_SE:    if (vx == nn) pc <= pc4;
            GRP_SNE:   if (vx != nn) pc <= pc4;
            GRP_SEXY:  if (vx == vy) pc <= pc4;
            GRP_SNEXY: if (vx != vy) pc <= pc4;
            GRP_LDI:   index <= {4'd0, nnn};
            GRP_JPV0:  pc <= nnn + {4'd0, v0};
            GRP_DRW: begin
              drew <= 1'b1;
              coll <= 1'b0;
              flag <= 1'b0;
              state <= (nlo == 4'd0) ? S_WRF : S_DROW;
            end
            GRP_SKP: begin
              if (nn == SKP_DOWN) begin
                if (key_hit) pc <= pc4;
              end else if (nn == SKP_UP) begin
                if (!key_hit) pc <= pc4;
              end else bad <= 1'b1;
            end
            GRP_MISC: begin
              priority case (nn)
                F_GET_DT: ;
                F_WAIT_KEY: if (keys == 16'd0) pc <= pc;
                F_SET_DT: delay <= vx;
                F_SET_ST: sound <= vx;
                F_ADD_I: begin
                  index <= isum[15:0];
                  flag  <= (isum[15:0] > 16'h0FFF);
                  state <= S_WRF;
                end
                F_FONT:  index <= {6'd0, vx, 2'b00} + {8'd0, vx};
                F_BCD:   state <= S_BCD;
                F_STORE: state <= S_STRD;
                F_LOAD:  state <= S_LDRD;
                default: bad <= 1'b1;
              endcase
            end
            default: ;
          endcase
        end
        S_CLS: begin
          cnt <= cnt + 12'd1;
          if (cnt[SCR_AW-1:0] == SCR_AW'(SCREEN_PIXELS - 1)) state <= S_TIMER;
        end
        S_WRF:  state <= S_TIMER;
        S_DROW: state <= S_DBYTE;
        S_DBYTE: begin
          row_byte <= ram_rdata;
          bitpos   <= '0;
          state    <= S_DPIX;
        end
        S_DPIX, S_DRMW: begin
          if (state == S_DPIX && row_byte[3'd7 - bitpos]) begin
            state <= S_DRMW;
          end else begin
            if (state == S_DRMW) begin
              coll <= coll | scr_rdata;
              flag <= coll | scr_rdata;
            end
            bitpos <= bitpos + 3'd1;
            if (bitpos == 3'd7) begin
              if (row_last) state <= S_WRF;
              else begin
                cnt   <= cnt + 12'd1;
                state <= S_DROW;
              end
            end else state <= S_DPIX;
          end
        end
        S_BCD: begin
          cnt <= cnt + 12'd1;
          if (cnt[1:0] == 2'd2) state <= S_TIMER;
        end
        S_STRD: state <= S_STWR;
        S_LDRD: state <= S_LDWR;
        S_STWR, S_LDWR: begin
          cnt <= cnt + 12'd1;
          if (cnt[3:0] == rx) begin
            index <= index + {12'd0, rx} + 16'd1;
            state <= S_TIMER;
          end else state <= (state == S_STWR) ? S_STRD : S_LDRD;
        end
        S_TIMER: begin
          snd <= (sound != 8'd0);
          if (delay != 8'd0) delay <= delay - 8'd1;
          if (sound != 8'd0) sound <= sound - 8'd1;
          state <= S_DONE;
        end
        S_DONE: if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register: frees the core while the result waits downstream
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {bad, pc, (req_op == REQ_EXEC) ? snd : (sound != 8'd0), drew, pix};
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    state == S_DRMW |-> $past(state) == S_DPIX)
    else $error("screen write without prior read");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && state == S_IDLE)
    else $error("result not posted");

  a_exec_after_reads: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> $past(state) == S_RD0)
    else $error("execute without operand reads");

endmodule
`default_nettype wire

// ===== hdl/chip8_ram.sv =====
`default_nettype none
module chip8_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/chip8_alu.sv =====
`default_nettype none
module chip8_alu import chip8_pkg::*; (
  input  wire logic [15:0] opc,
  input  wire logic [7:0]  vx,
  input  wire logic [7:0]  vy,
  input  wire logic [7:0]  delay,
  input  wire logic [15:0] keys,
  input  wire logic [7:0]  rnd,
  output alu_res_t         res,
  output bcd_t             bcd
);
  logic [8:0]  sum;
  logic [3:0]  top_key;
  logic [1:0]  hund;
  logic [6:0]  rem;
  logic [14:0] prod;
  logic [3:0]  tens;

  assign sum = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    top_key = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (keys[i]) top_key = 4'(i);
    end
  end

  always_comb begin
    res = '0;
    unique case (opc[15:12])
      GRP_LD:  begin res.val = opc[7:0]; res.wr = 1'b1; end
      GRP_ADD: begin res.val = vx + opc[7:0]; res.wr = 1'b1; end
      GRP_RND: begin res.val = opc[7:0] & rnd; res.wr = 1'b1; end
      GRP_ALU: begin
        res.wr = 1'b1;
        unique case (opc[3:0])
          ALU_MOV: res.val = vy;
          ALU_OR:  res.val = vx | vy;
          ALU_AND: res.val = vx & vy;
          ALU_XOR: res.val = vx ^ vy;
          ALU_ADD: begin res.val = sum[7:0]; res.flag = sum[8]; res.flag_wr = 1'b1; end
          ALU_SUB: begin res.val = vx - vy; res.flag = (vx >= vy); res.flag_wr = 1'b1; end
          ALU_SHR: begin res.val = vx >> 1; res.flag = vx[0]; res.flag_wr = 1'b1; end
          ALU_SUBN: begin res.val = vy - vx; res.flag = (vy >= vx); res.flag_wr = 1'b1; end
          ALU_SHL: begin res.val = vx << 1; res.flag = vx[7]; res.flag_wr = 1'b1; end
          default: begin res.wr = 1'b0; res.bad = 1'b1; end
        endcase
      end
      GRP_MISC: begin
        if (opc[7:0] == F_GET_DT) begin
          res.val = delay;
          res.wr  = 1'b1;
        end else if (opc[7:0] == F_WAIT_KEY) begin
          res.val = {4'd0, top_key};
          res.wr  = (keys != 16'd0);
        end
      end
      default: res = '0;
    endcase
  end

  // decimal digits: hundreds by compare, tens by reciprocal multiply (r < 100)
  always_comb begin
    if (vx >= 8'd200)      hund = 2'd2;
    else if (vx >= 8'd100) hund = 2'd1;
    else                   hund = 2'd0;
    rem  = 7'(vx - 8'(hund) * 8'd100);
    prod = 15'(rem) * 15'd205;
    tens = 4'(prod >> 11);
    bcd.hundreds = {6'd0, hund};
    bcd.tens     = {4'd0, tens};
    bcd.ones     = {1'b0, rem - 7'(tens) * 7'd10};
  end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
  import chip8_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  chip8_instruction_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow machine state
  logic [7:0]  mem_m [RAM_BYTES];
  logic [7:0]  vreg [16];
  logic [15:0] idx_m;
  logic [11:0] pc_m;
  logic [11:0] stk_m [STACK_DEPTH];
  logic [SP_W-1:0] sp_m;
  logic [7:0]  dt_m, st_m;
  logic        scr_m [SCREEN_PIXELS];

  logic [15:0] status_q [$];   // expected result words, oldest first
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic core_reset_model();
    for (int i = 0; i < RAM_BYTES; i++) mem_m[i] = (i < FONT_BYTES) ? FONT[i] : 8'h00;
    for (int i = 0; i < 16; i++) vreg[i] = 8'h00;
    for (int i = 0; i < STACK_DEPTH; i++) stk_m[i] = '0;
    for (int i = 0; i < SCREEN_PIXELS; i++) scr_m[i] = 1'b0;
    idx_m = '0; pc_m = 12'(PROGRAM_START); sp_m = '0; dt_m = '0; st_m = '0;
  endtask

  // runs one instruction on the shadow state; returns {bad, drew}
  function automatic logic [1:0] run_insn(input logic [15:0] keys, input logic [7:0] rnd);
    logic [15:0] op;
    logic [3:0] x, y;
    logic [7:0] nn, vx, vy, row;
    logic [11:0] nnn;
    logic [8:0] sum;
    logic bad, drew;
    int p;
    op = {mem_m[pc_m], mem_m[pc_m + 12'd1]};
    x = op[11:8]; y = op[7:4]; nn = op[7:0]; nnn = op[11:0];
    vx = vreg[x]; vy = vreg[y];
    bad = 1'b0; drew = 1'b0;
    pc_m = pc_m + 12'd2;
    case (op[15:12])
      GRP_SYS:
        if (nn == SYS_CLS) begin
          for (int i = 0; i < SCREEN_PIXELS; i++) scr_m[i] = 1'b0;
          drew = 1'b1;
        end else if (nn == SYS_RET) begin
          sp_m = sp_m - 1'b1;
          pc_m = stk_m[sp_m];
        end else bad = 1'b1;
      GRP_JP: pc_m = nnn;
      GRP_CALL: begin
        stk_m[sp_m] = pc_m;
        sp_m = sp_m + 1'b1;
        pc_m = nnn;
      end
      GRP_SE:    if (vx == nn) pc_m = pc_m + 12'd2;
      GRP_SNE:   if (vx != nn) pc_m = pc_m + 12'd2;
      GRP_SEXY:  if (vx == vy) pc_m = pc_m + 12'd2;
      GRP_LD:    vreg[x] = nn;
      GRP_ADD:   vreg[x] = vx + nn;
      GRP_ALU:
        case (op[3:0])
          ALU_MOV: vreg[x] = vy;
          ALU_OR:  vreg[x] = vx | vy;
          ALU_AND: vreg[x] = vx & vy;
          ALU_XOR: vreg[x] = vx ^ vy;
          ALU_ADD: begin
            sum = vx + vy;
            vreg[x] = sum[7:0]; vreg[REG_FLAG] = {7'd0, sum[8]};
          end
          ALU_SUB:  begin vreg[x] = vx - vy; vreg[REG_FLAG] = {7'd0, vx >= vy}; end
          ALU_SHR:  begin vreg[x] = vx >> 1; vreg[REG_FLAG] = {7'd0, vx[0]}; end
          ALU_SUBN: begin vreg[x] = vy - vx; vreg[REG_FLAG] = {7'd0, vy >= vx}; end
          ALU_SHL:  begin vreg[x] = vx << 1; vreg[REG_FLAG] = {7'd0, vx[7]}; end
          default: bad = 1'b1;
        endcase
      GRP_SNEXY: if (vx != vy) pc_m = pc_m + 12'd2;
      GRP_LDI:   idx_m = {4'd0, nnn};
      GRP_JPV0:  pc_m = nnn + {4'd0, vreg[0]};
      GRP_RND:   vreg[x] = nn & rnd;
      GRP_DRW: begin
        vreg[REG_FLAG] = 8'd0;
        for (int i = 0; i < op[3:0]; i++) begin
          row = mem_m[12'(idx_m + i)];
          for (int j = 0; j < 8; j++)
            if (row[7-j]) begin
              p = ((vx + j) + (vy + i) * SCREEN_WIDTH) % SCREEN_PIXELS;
              if (scr_m[p]) vreg[REG_FLAG] = 8'd1;
              scr_m[p] = ~scr_m[p];
            end
        end
        drew = 1'b1;
      end
      GRP_SKP:
        if (nn == SKP_DOWN) begin
          if (keys[vx[3:0]]) pc_m = pc_m + 12'd2;
        end else if (nn == SKP_UP) begin
          if (!keys[vx[3:0]]) pc_m = pc_m + 12'd2;
        end else bad = 1'b1;
      default:
        case (nn)
          F_GET_DT: vreg[x] = dt_m;
          F_SET_DT: dt_m = vx;
          F_SET_ST: st_m = vx;
          F_ADD_I: begin
            idx_m = idx_m + vx;
            vreg[REG_FLAG] = {7'd0, idx_m > 16'hFFF};
          end
          F_WAIT_KEY:
            if (keys == 16'd0) pc_m = pc_m - 12'd2;
            else for (int i = 0; i < 16; i++) if (keys[i]) vreg[x] = 8'(i);
          F_FONT: idx_m = vx * 16'd5;
          F_BCD: begin
            mem_m[12'(idx_m)] = 8'(vx / 100);
            mem_m[12'(idx_m + 1)] = 8'((vx / 10) % 10);
            mem_m[12'(idx_m + 2)] = 8'(vx % 10);
          end
          F_STORE: begin
            for (int i = 0; i <= x; i++) mem_m[12'(idx_m + i)] = vreg[i];
            idx_m = idx_m + x + 16'd1;
          end
          F_LOAD: begin
            for (int i = 0; i <= x; i++) vreg[i] = mem_m[12'(idx_m + i)];
            idx_m = idx_m + x + 16'd1;
          end
          default: bad = 1'b1;
        endcase
    endcase
    return {bad, drew};
  endfunction

  function automatic logic [15:0] core_step(input logic [1:0] kind, input logic [11:0] addr,
                                            input logic [7:0] dat, input logic [15:0] keys,
                                            input logic [7:0] rnd);
    logic pix, snd;
    logic [1:0] bd;
    pix = 1'b0; bd = 2'b00; snd = (st_m != 0);
    if (kind == REQ_LOAD) mem_m[addr] = dat;
    else if (kind == REQ_EXEC) begin
      bd = run_insn(keys, rnd);
      if (dt_m != 0) dt_m--;
      snd = (st_m != 0);
      if (st_m != 0) st_m--;
    end else if (kind == REQ_PIXEL) pix = scr_m[addr[SCR_AW-1:0]];
    return {bd[1], pc_m, snd, bd[0], pix};
  endfunction

  // valid stays up between back-to-back requests; it drops only while idling
  task automatic send_request(input logic [1:0] kind, input logic [11:0] addr,
                              input logic [7:0] dat, input logic [15:0] keys,
                              input logic [7:0] rnd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {4'd0, rnd, keys, dat, addr};
    status_q.push_back(core_step(kind, addr, dat, keys, rnd));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic load_byte(input logic [11:0] a, input logic [7:0] d);
    send_request(REQ_LOAD, a, d, 16'd0, 8'd0);
  endtask

  task automatic exec_one(input logic [15:0] keys = 16'($urandom),
                          input logic [7:0] rnd = 8'($urandom));
    send_request(REQ_EXEC, 12'($urandom), 8'($urandom), keys, rnd);
  endtask

  // place one opcode at pc and run it
  task automatic run_op(input logic [15:0] op, input logic [15:0] keys = 16'($urandom));
    load_byte(pc_m, op[15:8]);
    load_byte(pc_m + 12'd1, op[7:0]);
    exec_one(keys);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        if (status_q.size() == 0) report("unexpected result", m_tdata, 16'h0);
        else begin
          logic [15:0] want;
          want = status_q.pop_front();
          if (m_tdata[0] !== want[0]) report("pixel", {15'd0, m_tdata[0]}, {15'd0, want[0]});
          if (m_tdata[1] !== want[1]) report("drew", {15'd0, m_tdata[1]}, {15'd0, want[1]});
          if (m_tdata[2] !== want[2])
            report("sound_on", {15'd0, m_tdata[2]}, {15'd0, want[2]});
          if (m_tdata[14:3] !== want[14:3])
            report("program_counter", {4'd0, m_tdata[14:3]}, {4'd0, want[14:3]});
          if (m_tdata[15] !== want[15])
            report("bad_opcode", {15'd0, m_tdata[15]}, {15'd0, want[15]});
        end
      end
    end
  end

  // watchdog: long enough for reset clearing pass plus a screen clear under stall
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 40000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_alu_and_flags();
    logic [15:0] ops [$];
    ops = '{16'h60FF, 16'h61FF, 16'h8014, 16'h6A00, 16'h6B01, 16'h8AB5, 16'h8AB7,
            16'h6C81, 16'h8C06, 16'h6C81, 16'h8C0E, 16'h6F80, 16'h8F0E, 16'h8121,
            16'h8122, 16'h8123, 16'h8120, 16'h7105, 16'h8129, 16'hC3FF};
    foreach (ops[i]) run_op(ops[i]);
  endtask

  task automatic test_flow_and_misc();
    logic [15:0] ops [$];
    ops = '{16'h0123, 16'h00E0, 16'h2300, 16'h00EE, 16'h3000, 16'h4000, 16'h5010,
            16'h9010, 16'hA123, 16'hB200, 16'hE09E, 16'hE0A1, 16'hE0FF, 16'h6045,
            16'hF015, 16'hF018, 16'hF007, 16'hF01E, 16'hF029, 16'hF033, 16'hF255,
            16'hF265, 16'hF0FF, 16'hAFFE, 16'hD015, 16'hD01F, 16'hF30A, 16'h1FFE};
    foreach (ops[i]) run_op(ops[i]);
    run_op(16'hF40A, 16'h0000);         // no key held: pc steps back
    run_op(16'hF40A, 16'h8001);
    for (int k = 0; k < 8; k++)
      send_request(REQ_PIXEL, 12'(12'hFFF - k), 8'h00, 16'h0, 8'h0);
    send_request(2'd3, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);  // unused operation
    exec_one();                          // runs from address 0 after pc wrapped past the top of RAM
  endtask

  task automatic test_random_programs(input int count);
    logic [15:0] op;
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        op = 16'($urandom);
        // keep screen clears and long draws rare; they are slow
        if (op[15:12] == GRP_SYS && $urandom_range(9) != 0) op[7:0] = SYS_RET;
        if (op[15:12] == GRP_SYS && op[7:0] == SYS_CLS && $urandom_range(3) != 0)
          op[7:0] = 8'hE1;
        if (op[15:12] == GRP_DRW && $urandom_range(3) != 0) op[3:0] = 4'($urandom_range(4));
        if (op[15:12] == GRP_MISC && $urandom_range(3) != 0) begin
          case ($urandom_range(9))
            0: op[7:0] = F_GET_DT;  1: op[7:0] = F_WAIT_KEY; 2: op[7:0] = F_SET_DT;
            3: op[7:0] = F_SET_ST;  4: op[7:0] = F_ADD_I;    5: op[7:0] = F_FONT;
            6: op[7:0] = F_BCD;     7: op[7:0] = F_STORE;    8: op[7:0] = F_LOAD;
            default: ;
          endcase
        end
        if (op[15:12] == GRP_ALU && $urandom_range(3) != 0)
          op[3:0] = ($urandom_range(1) != 0) ? 4'($urandom_range(7)) : ALU_SHL;
        run_op(op);
        n += 2;
      end else if (pick < 75) exec_one($urandom_range(1) ? 16'h0 : 16'($urandom));
      else if (pick < 88)
        send_request(REQ_PIXEL, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      else if (pick < 98) load_byte(12'($urandom), 8'($urandom));
      else send_request(2'd3, 12'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    core_reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_alu_and_flags();
    test_flow_and_misc();
    send_idle_pct = 18; recv_idle_pct = 64;
    test_random_programs(530);
    drain();                             // sender holds off until all results are in
    send_idle_pct = 64; recv_idle_pct = 18;
    test_random_programs(530);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random_programs(530);
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
